/* rtl/ipv4_header_parser_macros.svh */
// Assertion helpers for the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef IPV4_HEADER_PARSER_MACROS_SVH
`define IPV4_HEADER_PARSER_MACROS_SVH

// Same-cycle implication.
`define IPHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/iphp_pkg.sv */
package iphp_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int POS_W        = 5;

    localparam logic [POS_W-1:0] LAST_POS       = POS_W'(HEADER_BYTES - 1);
    localparam logic [15:0]      MIN_LENGTH     = 16'(HEADER_BYTES);
    localparam logic [3:0]       IP_VERSION_V4  = 4'd4;
    localparam logic [7:0]       IHL_MASK       = 8'h0F;
    localparam logic [3:0]       IHL_NO_OPTIONS = 4'd5;
    localparam logic [15:0]      SUM_ALL_ONES   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_TOO_SMALL        = 3'd1,
        ST_BAD_VERSION      = 3'd2,
        ST_BAD_IHL          = 3'd3,
        ST_BAD_TOTAL_LENGTH = 3'd4,
        ST_CHECKSUM         = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        start_of_buffer;
        logic [15:0] buffer_length;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [15:0] identification;
        logic [15:0] flags_and_offset;
        logic [15:0] total_length;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } result_t;

    // Ones'-complement add with end-around carry
    function automatic logic [15:0] csum_add(input logic [15:0] sum, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, sum} + {1'b0, word};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

/* rtl/iphp_if.sv */
interface iphp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        start_of_buffer;
    logic [15:0] buffer_length;

    modport source (output valid, byte_value, start_of_buffer, buffer_length, input ready);
    modport sink (input valid, byte_value, start_of_buffer, buffer_length, output ready);
endinterface

interface iphp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [15:0] identification;
    logic [15:0] flags_and_offset;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;

    modport source (output valid, status, time_to_live, protocol_number, identification,
                    flags_and_offset, total_length, source_address, destination_address,
                    input ready);
    modport sink (input valid, status, time_to_live, protocol_number, identification,
                  flags_and_offset, total_length, source_address, destination_address,
                  output ready);
endinterface

/* rtl/iphp_in_reg.sv */
module iphp_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  iphp_pkg::item_t in_item,
    output logic            in_ready,
    input  logic            advance,
    output logic            item_valid,
    output iphp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    iphp_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/iphp_hdr_core.sv */
module iphp_hdr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  iphp_pkg::item_t   item,
    input  logic              step,
    output logic              emit,
    output iphp_pkg::result_t result
);

    logic [iphp_pkg::POS_W-1:0] pos_reg;
    logic [iphp_pkg::POS_W-1:0] pos_next;
    logic                       active_reg;
    logic                       active_next;

    logic [15:0] sum_reg,  sum_next;
    logic [7:0]  hi_reg,   hi_next;
    logic [7:0]  vihl_reg, vihl_next;
    logic [15:0] blen_reg, blen_next;
    logic [31:0] frag_reg, frag_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] ltp_reg,  ltp_next;

    logic [iphp_pkg::POS_W-1:0] pos_base;
    logic [15:0] sum_base;
    logic [7:0]  hi_base;
    logic [7:0]  vihl_base;
    logic [31:0] frag_base;
    logic [63:0] addr_base;
    logic [31:0] ltp_base;

    logic            start;
    logic            too_small;
    logic            take;
    logic            last;
    logic [15:0]     tl;
    iphp_pkg::status_t verdict;

    assign start     = item.start_of_buffer;
    assign too_small = start && (item.buffer_length < iphp_pkg::MIN_LENGTH);
    assign take      = start || active_reg;

    // A start byte opens a fresh header
    assign pos_base  = start ? '0 : pos_reg;
    assign sum_base  = start ? '0 : sum_reg;
    assign hi_base   = start ? '0 : hi_reg;
    assign vihl_base = start ? '0 : vihl_reg;
    assign frag_base = start ? '0 : frag_reg;
    assign addr_base = start ? '0 : addr_reg;
    assign ltp_base  = start ? '0 : ltp_reg;
    assign blen_next = start ? item.buffer_length : blen_reg;

    assign last = (pos_base == iphp_pkg::LAST_POS);
    assign emit = item_valid && (too_small || (take && last));

    always_comb
    begin
        hi_next   = hi_base;
        sum_next  = sum_base;
        vihl_next = vihl_base;
        ltp_next  = ltp_base;
        frag_next = frag_base;
        addr_next = addr_base;
        if (!pos_base[0])
        begin
            hi_next = item.byte_value;
        end
        else
        begin
            sum_next = iphp_pkg::csum_add(sum_base, {hi_base, item.byte_value});
        end
        case (pos_base) inside
            5'd0:
            begin
                vihl_next = item.byte_value;
            end
            5'd2, 5'd3, 5'd8, 5'd9:
            begin
                ltp_next = {ltp_base[23:0], item.byte_value};
            end
            [5'd4:5'd7]:
            begin
                frag_next = {frag_base[23:0], item.byte_value};
            end
            [5'd12:5'd19]:
            begin
                addr_next = {addr_base[55:0], item.byte_value};
            end
            default:
            begin
            end
        endcase
    end

    assign tl = ltp_next[31:16];

    always_comb
    begin
        if (vihl_next[7:4] != iphp_pkg::IP_VERSION_V4)
        begin
            verdict = iphp_pkg::ST_BAD_VERSION;
        end
        else if ((vihl_next & iphp_pkg::IHL_MASK) != {4'b0, iphp_pkg::IHL_NO_OPTIONS})
        begin
            verdict = iphp_pkg::ST_BAD_IHL;
        end
        else if ((tl < iphp_pkg::MIN_LENGTH) || (tl > blen_next))
        begin
            verdict = iphp_pkg::ST_BAD_TOTAL_LENGTH;
        end
        else if ((sum_next != 16'h0000) && (sum_next != iphp_pkg::SUM_ALL_ONES))
        begin
            verdict = iphp_pkg::ST_CHECKSUM;
        end
        else
        begin
            verdict = iphp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        result = '0;
        if (too_small)
        begin
            result.status = iphp_pkg::ST_TOO_SMALL;
        end
        else
        begin
            result.status = verdict;
            if (verdict == iphp_pkg::ST_OK)
            begin
                result.time_to_live        = ltp_next[15:8];
                result.protocol_number     = ltp_next[7:0];
                result.identification      = frag_next[31:16];
                result.flags_and_offset    = frag_next[15:0];
                result.total_length        = tl;
                result.source_address      = addr_next[63:32];
                result.destination_address = addr_next[31:0];
            end
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        active_next = active_reg;
        if (too_small)
        begin
            pos_next    = '0;
            active_next = 1'b0;
        end
        else if (take)
        begin
            pos_next    = last ? '0 : pos_base + 1'b1;
            active_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
        end
    end

    // Header payload; only read after a start byte has rewritten it
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            blen_reg <= blen_next;
            if (take && !too_small)
            begin
                sum_reg  <= sum_next;
                hi_reg   <= hi_next;
                vihl_reg <= vihl_next;
                frag_reg <= frag_next;
                addr_reg <= addr_next;
                ltp_reg  <= ltp_next;
            end
        end
    end

endmodule

/* rtl/iphp_out_reg.sv */
module iphp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  iphp_pkg::result_t push_data,
    input  logic              pop,
    output logic              free,
    output logic              valid,
    output iphp_pkg::result_t data
);

    logic              valid_reg;
    logic              valid_next;
    iphp_pkg::result_t data_reg;

    assign free  = !valid_reg || pop;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

/* rtl/ipv4_header_parser.sv */
// Throughput: one byte transaction per cycle, with no bubbles between buffers, unless a result is held back.
// A result is pushed into the result register as the final header byte (or a short start
// byte) leaves the input register, in which every byte is first registered.
// The single-entry result register lets input continue while a result waits on res.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the parser idle.
module ipv4_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    iphp_in_if.sink      pkt,
    iphp_res_if.source   res
);

    iphp_pkg::item_t   in_item;
    iphp_pkg::item_t   item;
    iphp_pkg::result_t core_result;
    iphp_pkg::result_t out_data;
    logic              item_valid;
    logic              emit;
    logic              out_free;
    logic              out_valid;
    logic              advance;

    assign in_item.byte_value      = pkt.byte_value;
    assign in_item.start_of_buffer = pkt.start_of_buffer;
    assign in_item.buffer_length   = pkt.buffer_length;

    // Hold the byte only if it produces a result and the result register is full and not being read
    assign advance = item_valid && (!emit || out_free);

    iphp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pkt.valid),
        .in_item    (in_item),
        .in_ready   (pkt.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    iphp_hdr_core u_hdr_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .step       (advance),
        .emit       (emit),
        .result     (core_result)
    );

    iphp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit && advance),
        .push_data (core_result),
        .pop       (res.ready),
        .free      (out_free),
        .valid     (out_valid),
        .data      (out_data)
    );

    assign res.valid               = out_valid;
    assign res.status              = out_data.status;
    assign res.time_to_live        = out_data.time_to_live;
    assign res.protocol_number     = out_data.protocol_number;
    assign res.identification      = out_data.identification;
    assign res.flags_and_offset    = out_data.flags_and_offset;
    assign res.total_length        = out_data.total_length;
    assign res.source_address      = out_data.source_address;
    assign res.destination_address = out_data.destination_address;

endmodule

/* rtl/iphp_checker.sv */
`include "ipv4_header_parser_macros.svh"

module iphp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [7:0]  time_to_live,
    input logic [7:0]  protocol_number,
    input logic [15:0] identification,
    input logic [15:0] flags_and_offset,
    input logic [15:0] total_length,
    input logic [31:0] source_address,
    input logic [31:0] destination_address
);

    logic fields_zero;

    assign fields_zero = (time_to_live == 8'd0) && (protocol_number == 8'd0)
                         && (identification == 16'd0) && (flags_and_offset == 16'd0)
                         && (total_length == 16'd0) && (source_address == 32'd0)
                         && (destination_address == 32'd0);

    `IPHP_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid, "result dropped while stalled")
    `IPHP_ASSERT_NOW(a_fail_zero, res_valid && (status != iphp_pkg::ST_OK), fields_zero, "failed result carries fields")
    `IPHP_ASSERT_NOW(a_ok_length, res_valid && (status == iphp_pkg::ST_OK), total_length >= iphp_pkg::MIN_LENGTH, "ok result with short total length")
    `IPHP_ASSERT_NOW(a_rose_cause, $rose(res_valid), $past(in_valid && in_ready, 2), "result without an input transaction")

endmodule

bind ipv4_header_parser iphp_checker u_iphp_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (pkt.valid),
    .in_ready            (pkt.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .status              (res.status),
    .time_to_live        (res.time_to_live),
    .protocol_number     (res.protocol_number),
    .identification      (res.identification),
    .flags_and_offset    (res.flags_and_offset),
    .total_length        (res.total_length),
    .source_address      (res.source_address),
    .destination_address (res.destination_address)
);
